// File: rtl/pwcc_pkg.sv
// ----------------------------------------------------------------------------
// pwcc_pkg
// shared widths, register indexes and window constants for the pid unit
// ----------------------------------------------------------------------------
package pwcc_pkg;

    // error window
    localparam int WINDOW_DEPTH = 8;
    localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // datapath widths
    localparam int DATA_W = 16;
    localparam int GAIN_W = 16;
    localparam int ERR_W  = DATA_W + 1;
    localparam int SUM_W  = ERR_W + $clog2(WINDOW_DEPTH);
    localparam int DIFF_W = ERR_W + 1;
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + SUM_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int ACC_W  = PI_W + 2;
    localparam int SHIFT  = 8;
    localparam int RAW_W  = ACC_W - SHIFT;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd5;

    localparam logic signed [DATA_W-1:0] DRIVE_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] DRIVE_MIN = 16'sh8000;

endpackage

// File: rtl/pwcc_ram.sv
// ----------------------------------------------------------------------------
// pwcc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pwcc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pid_windowed_clamped_controller_unit.sv
// pipeline: an input transaction reaches the earliest result transaction through
//   five register stages: window read, sum update, products, accumulate, output
// throughput: one sample per cycle while m_axis_tready does not stall; set by the
//   single window ram read-modify-write per sample, forwarding back-to-back hits
// reset: synchronous active-low i_rst_n clears gains, restores limits, clears
//   the window sum, prior error, position and the per-entry window valid bits
// ----------------------------------------------------------------------------
// pid_windowed_clamped_controller_unit
// windowed pid controller with inclusive output clamp and optional reversal
// ----------------------------------------------------------------------------
module pid_windowed_clamped_controller_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [pwcc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pwcc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,   // target_value [31:16], measured_value [15:0]
    // drive stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,   // drive_value
    output logic                                 m_axis_tuser    // was_clamped
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic signed [pwcc_pkg::DATA_W-1:0] r_upper, r_lower;
    logic                               r_reverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_upper   <= pwcc_pkg::DRIVE_MAX;
            r_lower   <= pwcc_pkg::DRIVE_MIN;
            r_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwcc_pkg::CFG_GAIN_P:  r_kp      <= i_cfg_data;
                pwcc_pkg::CFG_GAIN_I:  r_ki      <= i_cfg_data;
                pwcc_pkg::CFG_GAIN_D:  r_kd      <= i_cfg_data;
                pwcc_pkg::CFG_UPPER:   r_upper   <= i_cfg_data;
                pwcc_pkg::CFG_LOWER:   r_lower   <= i_cfg_data;
                pwcc_pkg::CFG_REVERSE: r_reverse <= i_cfg_data[0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids and per-stage advance
    // each stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic adv_o, adv4, adv3, adv2, adv1;
    logic in_take;

    assign adv_o   = !r_vo || m_axis_tready;
    assign adv4    = !r_v4 || adv_o;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign in_take = s_axis_tvalid && adv1;

    assign s_axis_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1)  r_v1 <= s_axis_tvalid;
            if (adv2)  r_v2 <= r_v1;
            if (adv3)  r_v3 <= r_v2;
            if (adv4)  r_v4 <= r_v3;
            if (adv_o) r_vo <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: form the error, issue the window read at the oldest slot
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::DATA_W-1:0] in_meas, in_target;
    logic signed [pwcc_pkg::ERR_W-1:0]  in_err;
    logic [pwcc_pkg::POS_W-1:0]         r_pos, n_pos;

    assign in_meas   = s_axis_tdata[15:0];
    assign in_target = s_axis_tdata[31:16];
    assign in_err    = {in_meas[pwcc_pkg::DATA_W-1], in_meas}
                     - {in_target[pwcc_pkg::DATA_W-1], in_target};

    always_comb begin
        if (r_pos == pwcc_pkg::POS_W'(pwcc_pkg::WINDOW_DEPTH - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_take) begin
            r_pos <= n_pos;
        end
    end

    // stage 1 payload
    logic signed [pwcc_pkg::ERR_W-1:0] r_s1_err;
    logic [pwcc_pkg::POS_W-1:0]        r_s1_pos;
    logic                              r_s1_fwd;
    logic signed [pwcc_pkg::ERR_W-1:0] r_s1_fwd_err;

    // the item in stage 1 writes its slot in the same cycle the next read is
    // issued; the ram returns the old word, so the new one is forwarded
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_err     <= in_err;
            r_s1_pos     <= r_pos;
            r_s1_fwd     <= r_v1 && (r_s1_pos == r_pos);
            r_s1_fwd_err <= r_s1_err;
        end
    end

    // ------------------------------------------------------------------
    // error window ram, with a valid bit per slot standing in for reset
    // ------------------------------------------------------------------
    logic                              win_we;
    logic [pwcc_pkg::ERR_W-1:0]        win_rdata;
    logic [pwcc_pkg::WINDOW_DEPTH-1:0] r_win_vld;

    assign win_we = r_v1 && adv2;

    pwcc_ram #(
        .WIDTH (pwcc_pkg::ERR_W),
        .DEPTH (pwcc_pkg::WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_s1_pos),
        .i_wdata (r_s1_err),
        .i_re    (adv1),
        .i_raddr (r_pos),
        .o_rdata (win_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
        end else if (win_we) begin
            r_win_vld[r_s1_pos] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: evict oldest error, update running sum and prior error
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::ERR_W-1:0]  old_err;
    logic signed [pwcc_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic signed [pwcc_pkg::ERR_W-1:0]  r_prior;
    logic signed [pwcc_pkg::DIFF_W-1:0] s1_diff;

    always_comb begin
        if (r_s1_fwd) begin
            old_err = r_s1_fwd_err;
        end else if (r_win_vld[r_s1_pos]) begin
            old_err = win_rdata;
        end else begin
            old_err = '0;
        end
        n_sum   = r_sum - pwcc_pkg::SUM_W'(old_err) + pwcc_pkg::SUM_W'(r_s1_err);
        s1_diff = pwcc_pkg::DIFF_W'(r_s1_err) - pwcc_pkg::DIFF_W'(r_prior);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_prior <= '0;
        end else if (win_we) begin
            r_sum   <= n_sum;
            r_prior <= r_s1_err;
        end
    end

    logic signed [pwcc_pkg::ERR_W-1:0]  r_s2_err;
    logic signed [pwcc_pkg::SUM_W-1:0]  r_s2_sum;
    logic signed [pwcc_pkg::DIFF_W-1:0] r_s2_diff;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_err  <= r_s1_err;
            r_s2_sum  <= n_sum;
            r_s2_diff <= s1_diff;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: the three gain products
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::PP_W-1:0] r_prod_p;
    logic signed [pwcc_pkg::PI_W-1:0] r_prod_i;
    logic signed [pwcc_pkg::PD_W-1:0] r_prod_d;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_prod_p <= r_kp * r_s2_err;
            r_prod_i <= r_ki * r_s2_sum;
            r_prod_d <= r_kd * r_s2_diff;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: exact accumulate
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_acc <= pwcc_pkg::ACC_W'(r_prod_p)
                   + pwcc_pkg::ACC_W'(r_prod_i)
                   + pwcc_pkg::ACC_W'(r_prod_d);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: floor shift, clamp (upper tested first), reverse
    // ------------------------------------------------------------------
    logic signed [pwcc_pkg::RAW_W-1:0]  raw;
    logic signed [pwcc_pkg::RAW_W-1:0]  upper_ext, lower_ext;
    logic signed [pwcc_pkg::DATA_W-1:0] clamp_val, drive_val;
    logic                               clamp_hit;

    always_comb begin
        raw       = pwcc_pkg::RAW_W'(r_acc >>> pwcc_pkg::SHIFT);
        upper_ext = pwcc_pkg::RAW_W'(r_upper);
        lower_ext = pwcc_pkg::RAW_W'(r_lower);
        if (raw > upper_ext) begin
            clamp_val = r_upper;
            clamp_hit = 1'b1;
        end else if (raw < lower_ext) begin
            clamp_val = r_lower;
            clamp_hit = 1'b1;
        end else begin
            clamp_val = raw[pwcc_pkg::DATA_W-1:0];
            clamp_hit = 1'b0;
        end
        // negating the most negative drive saturates to the top value
        if (!r_reverse) begin
            drive_val = clamp_val;
        end else if (clamp_val == pwcc_pkg::DRIVE_MIN) begin
            drive_val = pwcc_pkg::DRIVE_MAX;
        end else begin
            drive_val = -clamp_val;
        end
    end

    logic [pwcc_pkg::DATA_W-1:0] r_out_drive;
    logic                        r_out_clamp;

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_out_drive <= drive_val;
            r_out_clamp <= clamp_hit;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_clamp;

endmodule
